FILE: hdl/modexp_pkg.sv
// shared constants and types for the modular exponentiation core
package modexp_pkg;

  localparam int VALUE_BITS = 31;
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [VALUE_BITS:0]   wide_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  localparam value_t MODULUS_RESET = value_t'(64'd2147483647);
  localparam value_t VALUE_ONE     = value_t'(1);
  localparam value_t VALUE_ZERO    = '0;

  typedef struct packed {
    logic   go;
    value_t multiplier;
    value_t multiplicand;
  } mul_req_t;

  typedef struct packed {
    logic   done;
    value_t product;
  } mul_rsp_t;

endpackage

FILE: hdl/modexp_mul.sv
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
module modexp_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  modexp_pkg::value_t modulus,
  input  modexp_pkg::mul_req_t req,
  output modexp_pkg::mul_rsp_t rsp
);
  import modexp_pkg::*;

  value_t mpl_r, mpl_nxt;
  value_t x_r, x_nxt;
  value_t acc_r, acc_nxt;
  cnt_t   cnt_r, cnt_nxt;
  logic   run_r, run_nxt;
  logic   done_r, done_nxt;

  wide_t dbl, dbl_red, sum, sum_red, mod_w;

  always_comb begin
    mod_w   = {1'b0, modulus};
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= mod_w) ? dbl - mod_w : dbl;
    sum     = dbl_red + (mpl_r[VALUE_BITS-1] ? {1'b0, x_r} : '0);
    sum_red = (sum >= mod_w) ? sum - mod_w : sum;
  end

  always_comb begin
    mpl_nxt  = mpl_r;
    x_nxt    = x_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.go) begin
      mpl_nxt = req.multiplier;
      x_nxt   = req.multiplicand;
      acc_nxt = '0;
      cnt_nxt = cnt_t'(VALUE_BITS);
      run_nxt = 1'b1;
    end else if (run_r) begin
      acc_nxt = sum_red[VALUE_BITS-1:0];
      mpl_nxt = {mpl_r[VALUE_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r - cnt_t'(1);
      if (cnt_r == cnt_t'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    mpl_r <= mpl_nxt;
    x_r   <= x_nxt;
    acc_r <= acc_nxt;
  end

  assign rsp.done    = done_r;
  assign rsp.product = acc_r;

endmodule

FILE: hdl/modular_exponentiation_core.sv
// modular exponentiation core: right-to-left square and multiply
//
//   channel   direction  handshake             payload
//   in        input      start / busy          in_base_value, in_exponent
//   out       output     out_valid strobe      out_power_result
//   cfg       input      cfg_valid / cfg_ready cfg_modulus
//
// exponent 0 or 1, or modulus below 2: result in the cycle after accept
// otherwise the base is reduced, then for each exponent bit a multiply if the bit is one and a square
// unless it is the highest one bit, all on the bit-serial multiplier (one bit a cycle)
// one transaction at a time; busy stays high until the result strobe
// synchronous active-low reset; modulus resets to 2^31 - 1; cfg_ready only idle without start
// the receiver cannot stall; out_valid lasts exactly one cycle
module modular_exponentiation_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  modexp_pkg::value_t in_base_value,
  input  modexp_pkg::value_t in_exponent,
  output logic               out_valid,
  output modexp_pkg::value_t out_power_result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  modexp_pkg::value_t cfg_modulus
);
  import modexp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_BIT,
    ST_ACC,
    ST_NEXT,
    ST_SQ
  } state_t;

  state_t   state_r, state_nxt;
  value_t   mod_r, mod_nxt;
  value_t   expo_r, expo_nxt;
  value_t   acc_r, acc_nxt;
  value_t   sq_r, sq_nxt;
  logic     valid_r, valid_nxt;
  value_t   res_r, res_nxt;
  mul_req_t req;
  mul_rsp_t rsp;
  value_t   expo_sh;

  modexp_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .modulus (mod_r),
    .req     (req),
    .rsp     (rsp)
  );

  always_comb begin
    state_nxt = state_r;
    mod_nxt   = mod_r;
    expo_nxt  = expo_r;
    acc_nxt   = acc_r;
    sq_nxt    = sq_r;
    valid_nxt = 1'b0;
    res_nxt   = res_r;
    req       = '{go: 1'b0, multiplier: sq_r, multiplicand: sq_r};
    expo_sh   = {1'b0, expo_r[VALUE_BITS-1:1]};

    case (state_r)
      ST_IDLE: begin
        if (cfg_valid && !start) begin
          mod_nxt = cfg_modulus;
        end
        if (start) begin
          expo_nxt = in_exponent;
          if (in_exponent == VALUE_ZERO) begin
            valid_nxt = 1'b1;
            res_nxt   = VALUE_ONE;
          end else if (in_exponent == VALUE_ONE) begin
            valid_nxt = 1'b1;
            res_nxt   = in_base_value;
          end else if (mod_r < value_t'(2)) begin
            valid_nxt = 1'b1;
            res_nxt   = VALUE_ZERO;
          end else begin
            req       = '{go: 1'b1, multiplier: in_base_value, multiplicand: VALUE_ONE};
            state_nxt = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (rsp.done) begin
          sq_nxt    = rsp.product;
          acc_nxt   = VALUE_ONE;
          state_nxt = ST_BIT;
        end
      end
      ST_BIT: begin
        if (expo_r[0]) begin
          req       = '{go: 1'b1, multiplier: acc_r, multiplicand: sq_r};
          state_nxt = ST_ACC;
        end else begin
          state_nxt = ST_NEXT;
        end
      end
      ST_ACC: begin
        if (rsp.done) begin
          acc_nxt   = rsp.product;
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        expo_nxt = expo_sh;
        if (expo_sh != VALUE_ZERO) begin
          req       = '{go: 1'b1, multiplier: sq_r, multiplicand: sq_r};
          state_nxt = ST_SQ;
        end else begin
          valid_nxt = 1'b1;
          res_nxt   = acc_r;
          state_nxt = ST_IDLE;
        end
      end
      ST_SQ: begin
        if (rsp.done) begin
          sq_nxt    = rsp.product;
          state_nxt = ST_BIT;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mod_r   <= MODULUS_RESET;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mod_r   <= mod_nxt;
      valid_r <= valid_nxt;
    end
    expo_r <= expo_nxt;
    acc_r  <= acc_nxt;
    sq_r   <= sq_nxt;
    res_r  <= res_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign cfg_ready        = (state_r == ST_IDLE) && !start;
  assign out_valid        = valid_r;
  assign out_power_result = res_r;

endmodule

FILE: hdl/modexp_checker.sv
// port-level checks for the modular exponentiation core, with bind
module modexp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input modexp_pkg::value_t in_base_value,
  input modexp_pkg::value_t in_exponent,
  input logic               out_valid,
  input modexp_pkg::value_t out_power_result
);
  import modexp_pkg::*;

  // accepted transaction either gives a result next or keeps the core busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted transaction neither busy nor answered");

  // a result comes from a direct answer or from the end of a busy period
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start && !busy) || $fell(busy)))
    else $error("result strobe without a transaction");

  // entering busy never coincides with a result
  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> !out_valid)
    else $error("result strobe while starting a long transaction");

  // exponent zero answers one
  a_expo_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_exponent == VALUE_ZERO)) |=>
      (out_valid && (out_power_result == VALUE_ONE)))
    else $error("exponent zero gave wrong result");

  // exponent one answers the base unreduced
  a_expo_one: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_exponent == VALUE_ONE)) |=>
      (out_valid && (out_power_result == $past(in_base_value))))
    else $error("exponent one gave wrong result");

endmodule

bind modular_exponentiation_core modexp_checker u_modexp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_base_value    (in_base_value),
  .in_exponent      (in_exponent),
  .out_valid        (out_valid),
  .out_power_result (out_power_result)
);
